### rtl/pee_pkg.sv
package pee_pkg;

	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_MUL   = 8'h2A;
	localparam logic [7:0] CH_DIV   = 8'h2F;
	localparam logic [7:0] CH_MOD   = 8'h25;
	localparam logic [7:0] CH_POW   = 8'h5E;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	typedef enum logic [1:0] {
		ERR_NONE  = 2'd0,
		ERR_EMPTY = 2'd1,
		ERR_DIV0  = 2'd2,
		ERR_OVF   = 2'd3
	} err_t;

	typedef enum logic [1:0] {
		AOP_DIV = 2'd0,
		AOP_MOD = 2'd1,
		AOP_POW = 2'd2
	} aop_t;

	typedef struct packed {
		logic  start;
		aop_t  op;
		logic [31:0] lhs;
		logic [31:0] rhs;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		logic [31:0] res;
	} alu_rsp_t;

endpackage

### rtl/postfix_expression_evaluator_unit.sv
// Digit and separator items are handled in S_IDLE. + - *: two stack reads, one write.
// / and %: 32 bit-serial divide steps on the shared unit; a zero divisor skips the unit.
// ^: one square-and-multiply step per exponent bit; a negative exponent gives a fixed result.
// Item flagged last: S_END pushes, then S_TOP reads the top, before the result register loads.
// The result sits in an output register; the next item is taken while it waits.
// arst_n clears count, number, error and control state; stack RAM is not cleared.
module postfix_expression_evaluator_unit
	import pee_pkg::*;
#(
	parameter int STACK_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         symbol,
	input  logic               last_symbol,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] value,
	output logic [1:0]         error_code
);
	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_RDR  = 8'b0000_0010,
		S_RDL  = 8'b0000_0100,
		S_OP   = 8'b0000_1000,
		S_WAIT = 8'b0001_0000,
		S_END  = 8'b0010_0000,
		S_TOP  = 8'b0100_0000,
		S_OUT  = 8'b1000_0000
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q;
	logic [31:0] num_q, rhs_q, lhs_q;
	logic        innum_q, last_q;
	err_t        err_q;
	logic [7:0]  op_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	logic [31:0]   wdata, rdata;
	alu_req_t      areq;
	alu_rsp_t      arsp;

	pee_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
		.clk, .we, .waddr, .wdata, .raddr, .rdata
	);
	pee_alu u_alu (.clk, .arst_n, .req(areq), .rsp(arsp));

	logic is_digit, is_op, accept, full;
	assign is_digit = symbol >= CH_ZERO && symbol <= CH_NINE;
	assign is_op = symbol == CH_PLUS || symbol == CH_MINUS || symbol == CH_MUL
		|| symbol == CH_DIV || symbol == CH_MOD || symbol == CH_POW;
	assign in_stall = state_q != S_IDLE;
	assign accept = in_valid && !in_stall;
	assign full = cnt_q >= CW'(STACK_DEPTH);

	// push logic for an item's pending number
	logic push_now, go_op;
	assign push_now = accept && err_q == ERR_NONE && !is_digit && innum_q && !full;
	assign go_op = accept && err_q == ERR_NONE && !is_digit && !(innum_q && full) && is_op
		&& (cnt_q + CW'(push_now)) >= CW'(2);

	always_comb begin
		we    = 1'b0;
		waddr = cnt_q[AW-1:0];
		wdata = num_q;
		raddr = cnt_q[AW-1:0] - AW'(1);
		if (push_now) we = 1'b1;
		if (state_q == S_END && err_q == ERR_NONE && innum_q && !full) we = 1'b1;
		if (state_q == S_RDR) raddr = cnt_q[AW-1:0] - AW'(2);
		if (state_q == S_OP || (state_q == S_WAIT && arsp.done)) begin
			waddr = cnt_q[AW-1:0];
			wdata = (state_q == S_WAIT) ? arsp.res :
				(op_q == CH_PLUS) ? lhs_q + rdata :
				(op_q == CH_MINUS) ? lhs_q - rdata : lhs_q * rdata;
		end
		if (state_q == S_WAIT && arsp.done) we = 1'b1;
		if (state_q == S_OP && (op_q == CH_PLUS || op_q == CH_MINUS || op_q == CH_MUL))
			we = 1'b1;
		areq.start = state_q == S_OP && !(op_q == CH_PLUS || op_q == CH_MINUS
			|| op_q == CH_MUL) && !((op_q == CH_DIV || op_q == CH_MOD) && rdata == 32'd0);
		areq.op  = (op_q == CH_DIV) ? AOP_DIV : (op_q == CH_MOD) ? AOP_MOD : AOP_POW;
		areq.lhs = lhs_q;
		areq.rhs = rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			num_q     <= '0;
			innum_q   <= 1'b0;
			err_q     <= ERR_NONE;
			out_valid <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			if (out_valid && !out_stall && state_q != S_OUT) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						last_q  <= last_symbol;
						op_q    <= symbol;
						state_q <= go_op ? S_RDR : (last_symbol ? S_END : S_IDLE);
						if (err_q == ERR_NONE) begin
							if (is_digit) begin
								num_q <= innum_q ? 32'(num_q * 32'd10) + 32'(symbol - CH_ZERO)
									: 32'(symbol - CH_ZERO);
								innum_q <= 1'b1;
							end else begin
								innum_q <= 1'b0;
								if (innum_q && full) err_q <= ERR_OVF;
								else begin
									if (push_now) cnt_q <= cnt_q + CW'(1);
									if (is_op && !go_op) err_q <= ERR_EMPTY;
								end
							end
						end
					end
				end
				S_RDR: begin
					state_q <= S_RDL;
				end
				S_RDL: begin
					lhs_q   <= rdata;
					cnt_q   <= cnt_q - CW'(2);
					state_q <= S_OP;
				end
				S_OP: begin
					// rdata holds rhs now
					if (op_q == CH_PLUS || op_q == CH_MINUS || op_q == CH_MUL) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= last_q ? S_END : S_IDLE;
					end else if ((op_q == CH_DIV || op_q == CH_MOD) && rdata == 32'd0) begin
						err_q   <= ERR_DIV0;
						state_q <= last_q ? S_END : S_IDLE;
					end else state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (arsp.done) begin
						cnt_q   <= cnt_q + CW'(1);
						state_q <= last_q ? S_END : S_IDLE;
					end
				end
				S_END: begin
					if (err_q == ERR_NONE && innum_q) begin
						innum_q <= 1'b0;
						if (full) err_q <= ERR_OVF;
						else cnt_q <= cnt_q + CW'(1);
					end
					state_q <= S_TOP;
				end
				S_TOP: state_q <= S_OUT;
				S_OUT: begin
					if (!out_valid || !out_stall) begin
						out_valid  <= 1'b1;
						error_code <= (err_q == ERR_NONE && cnt_q == '0) ? ERR_EMPTY : err_q;
						value      <= (err_q == ERR_NONE && cnt_q != '0) ? rdata : 32'sd0;
						cnt_q   <= '0;
						num_q   <= '0;
						innum_q <= 1'b0;
						err_q   <= ERR_NONE;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### rtl/pee_ram.sv
module pee_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/pee_alu.sv
module pee_alu
	import pee_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);
	// one step per cycle: restoring divide bit, or square-and-multiply bit
	logic        busy_q;
	aop_t        op_q;
	logic [5:0]  cnt_q;
	logic [31:0] a_q;      // dividend shift / base
	logic [31:0] b_q;      // divisor / exponent
	logic [31:0] r_q;      // remainder / accumulator
	logic        neg_q;    // negate result
	logic        fix_q;    // pow result fixed, no iteration
	logic [32:0] trial;
	logic [31:0] l_mag, r_mag;

	assign l_mag = req.lhs[31] ? 32'(-req.lhs) : req.lhs;
	assign r_mag = req.rhs[31] ? 32'(-req.rhs) : req.rhs;
	assign trial = {r_q, a_q[31]} - {1'b0, b_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			rsp.done <= 1'b0;
		end else begin
			rsp.done <= busy_q && !req.start &&
				((op_q == AOP_POW) ? (fix_q || b_q == 32'd0) : (cnt_q == 6'd32));
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= 6'd0;
				if (req.op == AOP_POW) begin
					a_q   <= req.lhs;
					b_q   <= req.rhs;
					neg_q <= 1'b0;
					fix_q <= req.rhs[31];
					// negative exponent: only bases 1 and -1 give a nonzero result
					if (!req.rhs[31] || req.lhs == 32'd1) r_q <= 32'd1;
					else if (req.lhs == 32'hFFFF_FFFF)
						r_q <= req.rhs[0] ? 32'hFFFF_FFFF : 32'd1;
					else r_q <= 32'd0;
				end else begin
					a_q   <= l_mag;
					b_q   <= r_mag;
					r_q   <= 32'd0;
					fix_q <= 1'b0;
					neg_q <= (req.op == AOP_DIV) ? (req.lhs[31] ^ req.rhs[31]) : req.lhs[31];
				end
			end else if (busy_q) begin
				if (op_q == AOP_POW) begin
					if (fix_q || b_q == 32'd0) begin
						busy_q  <= 1'b0;
						rsp.res <= r_q;
					end else begin
						if (b_q[0]) r_q <= r_q * a_q;
						a_q <= a_q * a_q;
						b_q <= b_q >> 1;
					end
				end else if (cnt_q == 6'd32) begin
					busy_q <= 1'b0;
					if (op_q == AOP_DIV) rsp.res <= neg_q ? 32'(-a_q) : a_q;
					else rsp.res <= neg_q ? 32'(-r_q) : r_q;
				end else begin
					cnt_q <= cnt_q + 6'd1;
					if (!trial[32]) begin
						r_q <= trial[31:0];
						a_q <= {a_q[30:0], 1'b1};
					end else begin
						r_q <= {r_q[30:0], a_q[31]};
						a_q <= {a_q[30:0], 1'b0};
					end
				end
			end
		end
	end
endmodule

### rtl/pee_checker.sv
module pee_checker
	import pee_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_symbol,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] value,
	input logic [1:0]  error_code
);
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> value == 32'd0) else $error("value on error");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value)) else $error("result dropped");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_symbol |=> in_stall) else $error("end not busy");
endmodule

bind postfix_expression_evaluator_unit pee_checker u_chk (
	.clk, .arst_n, .in_valid, .in_stall, .last_symbol,
	.out_valid, .out_stall, .value, .error_code
);

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import pee_pkg::*;

	localparam int DEPTH = 16;

	// Mirrors the evaluator state; predicts one result per expression.
	class rpn_scoreboard;
		logic [31:0] stk [DEPTH];
		int unsigned cnt;
		logic [31:0] num;
		bit in_num;
		err_t err;
		logic [31:0] exp_value [$];
		err_t exp_err [$];
		int unsigned mismatches;

		function void clear();
			cnt = 0;
			num = 0;
			in_num = 0;
			err = ERR_NONE;
		endfunction

		function logic [31:0] pow32(logic [31:0] b, logic [31:0] e);
			logic [31:0] acc;
			acc = 1;
			if (e[31]) begin
				if (b == 32'd1) return 1;
				if (b == 32'hFFFF_FFFF) return e[0] ? 32'hFFFF_FFFF : 32'd1;
				return 0;
			end
			while (e != 0) begin
				if (e[0]) acc = acc * b;
				b = b * b;
				e = e >> 1;
			end
			return acc;
		endfunction

		function void push(logic [31:0] v);
			if (cnt >= DEPTH) begin
				err = ERR_OVF;
				return;
			end
			stk[cnt] = v;
			cnt++;
		endfunction

		function void apply_op(logic [7:0] op);
			logic [31:0] r, l, res, ml, mr;
			if (cnt < 2) begin
				err = ERR_EMPTY;
				return;
			end
			r = stk[cnt-1];
			l = stk[cnt-2];
			cnt -= 2;
			ml = l[31] ? -l : l;
			mr = r[31] ? -r : r;
			res = 0;
			case (op)
				CH_PLUS: res = l + r;
				CH_MINUS: res = l - r;
				CH_MUL: res = l * r;
				CH_DIV, CH_MOD: begin
					if (r == 0) begin
						err = ERR_DIV0;
						return;
					end
					if (op == CH_DIV) begin
						res = ml / mr;
						if (l[31] ^ r[31]) res = -res;
					end else begin
						res = ml % mr;
						if (l[31]) res = -res;
					end
				end
				default: res = pow32(l, r);
			endcase
			push(res);
		endfunction

		function void note_input(logic [7:0] c, bit last);
			logic [31:0] v;
			if (err == ERR_NONE) begin
				if (c >= CH_ZERO && c <= CH_NINE) begin
					num = in_num ? num * 10 + (c - CH_ZERO) : 32'(c - CH_ZERO);
					in_num = 1;
				end else begin
					if (in_num) begin
						in_num = 0;
						push(num);
					end
					if (err == ERR_NONE && (c == CH_PLUS || c == CH_MINUS || c == CH_MUL ||
							c == CH_DIV || c == CH_MOD || c == CH_POW))
						apply_op(c);
				end
			end
			if (!last) return;
			if (err == ERR_NONE && in_num) push(num);
			v = 0;
			if (err == ERR_NONE) begin
				if (cnt == 0) err = ERR_EMPTY;
				else v = stk[cnt-1];
			end
			if (err != ERR_NONE) v = 0;
			exp_value.push_back(v);
			exp_err.push_back(err);
			clear();
		endfunction

		function void check_result(logic [31:0] v, logic [1:0] e);
			logic [31:0] ev;
			err_t ee;
			if (exp_value.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result value=%0d err=%0d", $signed(v), e);
				return;
			end
			ev = exp_value.pop_front();
			ee = exp_err.pop_front();
			if (v !== ev || e !== ee) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: value exp %0d got %0d, err exp %0d got %0d",
						$signed(ev), $signed(v), ee, e);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] symbol;
	logic last_symbol;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] value;
	logic [1:0] error_code;

	rpn_scoreboard sb;
	int sent;
	bit quiet;
	bit hold_rx;
	byte unsigned expr_chars [$];

	postfix_expression_evaluator_unit #(.STACK_DEPTH(DEPTH)) uut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.symbol(symbol), .last_symbol(last_symbol), .out_valid(out_valid),
		.out_stall(out_stall), .value(value), .error_code(error_code)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#100ms;
		$display("FAIL postfix_expression_evaluator_unit");
		$finish;
	end

	// send one item, with random idle bursts ahead of it; valid stays up afterwards
	task automatic send_item(logic [7:0] c, bit last);
		int gap;
		if (!quiet && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 12);
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1;
		symbol <= c;
		last_symbol <= last;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_input(c, last);
		sent++;
	endtask

	task automatic send_expr();
		foreach (expr_chars[i]) send_item(expr_chars[i], i == expr_chars.size() - 1);
		expr_chars.delete();
	endtask

	task automatic add_str(string s);
		for (int i = 0; i < s.len(); i++) expr_chars.push_back(s[i]);
	endtask

	task automatic add_num(int unsigned n);
		add_str($sformatf("%0d ", n));
	endtask

	function automatic byte unsigned rand_op();
		byte unsigned ops [6];
		ops = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV, CH_MOD, CH_POW};
		return ops[$urandom_range(0, 5)];
	endfunction

	// well-formed expression with random content; occasional breakage
	task automatic build_random_expr();
		int depth, n, k;
		depth = 0;
		n = $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 3);
			if (depth < 2 || (k < 2 && depth < DEPTH + 1)) begin
				case ($urandom_range(0, 3))
					0: add_num($urandom_range(0, 9));
					1: add_num($urandom_range(0, 99));
					2: add_num($urandom_range(0, 3));
					default: add_num($urandom());
				endcase
				depth++;
			end else begin
				add_str(string'(rand_op()));
				depth--;
			end
		end
		while (depth > 1) begin
			expr_chars.push_back(rand_op());
			depth--;
		end
		if ($urandom_range(0, 9) == 0)
			expr_chars[$urandom_range(0, expr_chars.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 9) == 0) expr_chars.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic n_noise();
		int n;
		n = $urandom_range(1, 10);
		for (int i = 0; i < n; i++) expr_chars.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (sb.exp_value.size() != 0) @(posedge clk);
	endtask

	// receiver: random stall bursts, plus a forced long hold-off
	initial begin
		int gap;
		out_stall <= 1;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) sb.check_result(value, error_code);
			if (hold_rx) out_stall <= 1;
			else if (gap > 0) begin
				gap--;
				out_stall <= 1;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(0, 11);
				out_stall <= 1;
			end else out_stall <= 0;
		end
	end

	initial begin
		int wait_cyc;
		sb = new();
		sb.clear();
		sb.mismatches = 0;
		in_valid <= 0;
		symbol <= 0;
		last_symbol <= 0;
		arst_n <= 0;
		quiet = 0;
		hold_rx = 0;
		sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, each operator, each error
		add_str("3 4+"); send_expr();
		add_str("9 5-"); send_expr();
		add_str("6 7*"); send_expr();
		add_str("0 7-3/"); send_expr();
		add_str("0 7-3%"); send_expr();
		add_str("2 10^"); send_expr();
		add_str("2 0 1-^"); send_expr();
		add_str("0 1-0 3-^"); send_expr();
		add_str("1 0 5-^"); send_expr();
		add_str("2147483648 0 1-/"); send_expr();
		add_str("2147483648 0 1-%"); send_expr();
		add_str("99999999999"); send_expr();
		add_str("5 0/"); send_expr();
		add_str("5 0%"); send_expr();
		add_str("+"); send_expr();
		add_str(" "); send_expr();
		for (int i = 0; i < DEPTH + 1; i++) add_str("1 ");
		add_str("+"); send_expr();
		send_item(8'hFF, 0); send_item(8'h00, 0); send_item(8'd55, 1);

		// long receiver hold-off while the sender keeps going
		hold_rx = 1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_rx = 0;
			end
			for (int i = 0; i < 6; i++) begin
				add_str("12 34 56**");
				send_expr();
			end
		join
		wait_drained();

		while (sent < 1150) begin
			if (sent > 950) quiet = 1;
			if ($urandom_range(0, 9) == 0) begin
				n_noise();
			end else build_random_expr();
			send_expr();
		end
		in_valid <= 0;

		wait_cyc = 0;
		while (sb.exp_value.size() != 0 && wait_cyc < 100000) begin
			@(posedge clk);
			wait_cyc++;
		end
		repeat (100) @(posedge clk);
		if (sb.mismatches == 0 && sb.exp_value.size() == 0)
			$display("PASS postfix_expression_evaluator_unit");
		else
			$display("FAIL postfix_expression_evaluator_unit");
		$finish;
	end

endmodule

### postfix_expression_evaluator_unit.f
rtl/pee_pkg.sv
rtl/pee_ram.sv
rtl/pee_alu.sv
rtl/postfix_expression_evaluator_unit.sv
rtl/pee_checker.sv
test/tb_top.sv
